@@ src/crpb_pkg.sv @@
// Shared types and constants for the chunk reorder playout buffer.
package crpb_pkg;

    localparam int ID_W    = 31;
    localparam int HDL_W   = 16;
    localparam int SIZE_W  = 16;
    localparam int STAMP_W = 64;
    localparam int ALU_W   = 32;

    // Slot index search: digits of the id folded in per step, and step count.
    localparam int MOD_DIG   = 4;
    localparam int MOD_STEPS = ALU_W / MOD_DIG;

    typedef enum logic [1:0] {
        EV_PLAY = 2'd0,
        EV_LOST = 2'd1,
        EV_DUP  = 2'd2,
        EV_ERR  = 2'd3
    } t_event;

    typedef struct packed {
        logic [ID_W-1:0]    chunk_id;
        logic [HDL_W-1:0]   payload_handle;
        logic [SIZE_W-1:0]  payload_size;
        logic [STAMP_W-1:0] stamp;
    } t_in;

    typedef struct packed {
        t_event             event_kind;
        logic [ID_W-1:0]    out_id;
        logic [HDL_W-1:0]   out_handle;
        logic [SIZE_W-1:0]  out_size;
        logic [STAMP_W-1:0] out_stamp;
        logic [ID_W-1:0]    lost_count;
        logic               last_result;
    } t_out;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [HDL_W-1:0]   handle;
        logic [SIZE_W-1:0]  size;
        logic [STAMP_W-1:0] stamp;
    } t_slot;

endpackage

@@ src/crpb_alu.sv @@
// Shared add/subtract unit used by the sequencer steps.
module crpb_alu (
    input  logic [crpb_pkg::ALU_W-1:0] i_a,
    input  logic [crpb_pkg::ALU_W-1:0] i_b,
    input  logic                       i_sub,
    output logic [crpb_pkg::ALU_W-1:0] o_res,
    output logic                       o_borrow
);
    import crpb_pkg::*;

    logic [ALU_W:0] sum;

    always_comb begin
        sum = {1'b0, i_a} + {1'b0, (i_sub ? ~i_b : i_b)} + {{ALU_W{1'b0}}, i_sub};
    end

    assign o_res    = sum[ALU_W-1:0];
    assign o_borrow = i_sub & ~sum[ALU_W];

endmodule

@@ src/crpb_mod.sv @@
// Slot index of an id: id modulo RING_DEPTH; low bits for a power of two, else MOD_DIG bits per cycle.
module crpb_mod #(
    parameter int RING_DEPTH = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [crpb_pkg::ID_W-1:0]     i_value,
    output logic                          o_busy,
    output logic [$clog2(RING_DEPTH)-1:0] o_rem
);
    import crpb_pkg::*;

    localparam int  LW   = $clog2(RING_DEPTH);
    localparam bit  POW2 = (RING_DEPTH & (RING_DEPTH - 1)) == 0;
    localparam int  SW   = $clog2(MOD_STEPS);

    generate
        if (POW2) begin : g_pow2
            logic [LW-1:0] r_rem;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_rem <= '0;
                end else if (i_start) begin
                    r_rem <= i_value[LW-1:0];
                end
            end

            assign o_rem  = r_rem;
            assign o_busy = 1'b0;
        end else begin : g_iter
            logic [ALU_W-1:0] r_val;
            logic [LW-1:0]    r_rem;
            logic [LW-1:0]    n_rem;
            logic [SW-1:0]    r_step;
            logic             r_busy;

            // Restoring remainder over the top digit of the shift register.
            always_comb begin
                logic [LW:0] t;
                t     = '0;
                n_rem = r_rem;
                for (int j = 0; j < MOD_DIG; j++) begin
                    t = {n_rem, r_val[ALU_W-1-j]};
                    if (t >= (LW+1)'(RING_DEPTH)) begin
                        t = t - (LW+1)'(RING_DEPTH);
                    end
                    n_rem = t[LW-1:0];
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_busy <= 1'b0;
                    r_step <= '0;
                end else if (i_start) begin
                    r_busy <= 1'b1;
                    r_step <= '0;
                end else if (r_busy) begin
                    r_step <= r_step + SW'(1);
                    if (r_step == SW'(MOD_STEPS - 1)) begin
                        r_busy <= 1'b0;
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_val <= {{(ALU_W-ID_W){1'b0}}, i_value};
                    r_rem <= '0;
                end else if (r_busy) begin
                    r_val <= r_val << MOD_DIG;
                    r_rem <= n_rem;
                end
            end

            assign o_rem  = r_rem;
            assign o_busy = r_busy;
        end
    endgenerate

endmodule

@@ src/crpb_slots.sv @@
// Slot ring: valid flags in flops, descriptors in a registered-read memory.
module crpb_slots #(
    parameter int RING_DEPTH = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr,
    input  logic [$clog2(RING_DEPTH)-1:0] i_wr_addr,
    input  crpb_pkg::t_slot               i_wr_data,
    input  logic                          i_clr,
    input  logic [$clog2(RING_DEPTH)-1:0] i_clr_addr,
    input  logic [$clog2(RING_DEPTH)-1:0] i_rd_addr,
    output crpb_pkg::t_slot               o_rd_data,
    output logic [RING_DEPTH-1:0]         o_valid
);
    import crpb_pkg::*;

    t_slot                 mem [RING_DEPTH];
    t_slot                 r_rd;
    logic [RING_DEPTH-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rd <= mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_wr) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_clr) begin
                r_valid[i_clr_addr] <= 1'b0;
            end
        end
    end

    assign o_rd_data = r_rd;
    assign o_valid   = r_valid;

endmodule

@@ src/crpb_oreg.sv @@
// Output register stage between the sequencer and the result channel.
module crpb_oreg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  crpb_pkg::t_out i_item,
    output logic           o_can,
    output logic           o_valid,
    output crpb_pkg::t_out o_item,
    input  logic           i_ready
);
    import crpb_pkg::*;

    logic r_v;
    t_out r_item;

    assign o_can = !r_v || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_can) begin
            r_v <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can && i_push) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_v;
    assign o_item  = r_item;

endmodule

@@ src/chunk_reorder_playout_buffer_top.sv @@
// Chunk reorder playout buffer: sequencer around a shared add/subtract unit.
//
// Usage
//   Input channel (i_valid / o_ready, payload i_item) takes chunk
//   descriptors in any id order. Result channel (o_valid / i_ready, payload
//   o_item) gives play, lost, duplicate and collision items, plays in id order;
//   last_result marks the final item caused by one input item. A late chunk
//   gives no item at all.
//   One item is worked on at a time; o_ready is high only while idle.
//   Work per input item is least for a chunk that is only stored or
//   played at once; each stored chunk released, each position reported
//   lost, a window jump and a coalesced lost report add steps, as does
//   the slot index search when RING_DEPTH is not a power of two. Steps
//   share the one add/subtract unit and the one read port of the slot
//   memory, which sets the pace. A result item waits for the next one
//   (to know last_result), then passes through the output register.
//   Reset clears started, expected id and slot valid flags; no clearing pass.
//   When the receiver stalls, the sequencer holds at its next result and
//   resumes without loss once the output register drains.
module chunk_reorder_playout_buffer_top #(
    parameter int RING_DEPTH = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  crpb_pkg::t_in  i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output crpb_pkg::t_out o_item
);
    import crpb_pkg::*;

    localparam int LW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam logic [ALU_W-1:0] B32 = ALU_W'(RING_DEPTH);
    localparam logic [ALU_W-1:0] BM1 = ALU_W'(RING_DEPTH - 1);

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_MOD    = 13'b0000000000010,  // slot index search, late check
        S_JUMP   = 13'b0000000000100,  // positions the window has to pass
        S_WRD    = 13'b0000000001000,  // window step: slot read
        S_WUSE   = 13'b0000000010000,  // window step: play or lost
        S_EXTRA  = 13'b0000000100000,  // coalesced lost report
        S_LAST   = 13'b0000001000000,  // expected id after a long jump
        S_RRD    = 13'b0000010000000,  // release run: slot read
        S_RUSE   = 13'b0000100000000,  // release run: play
        S_ARRIVE = 13'b0001000000000,  // arriving id vs expected
        S_APLAY  = 13'b0010000000000,  // play the arriving chunk
        S_STORE  = 13'b0100000000000,  // store, duplicate or collision
        S_FIN    = 13'b1000000000000   // flush the held result as last
    } t_state;

    t_state          r_st, n_st;
    t_in             r_in, n_in;
    logic            r_started, n_started;
    logic [ID_W-1:0] r_exp, n_exp;
    logic [LW-1:0]   r_eslot, n_eslot;      // expected id modulo RING_DEPTH
    logic [ALU_W-1:0] r_tmp, n_tmp;         // distance, then positions passed
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_extra, n_extra;
    logic            r_after, n_after;
    t_out            r_pend, n_pend;        // result held until the next one
    logic            r_pend_v, n_pend_v;

    logic [ALU_W-1:0] alu_a, alu_b, alu_res;
    logic             alu_sub, alu_borrow;

    logic             mod_start, mod_busy;
    logic [LW-1:0]    mod_rem;

    logic                  slot_wr, slot_clr;
    logic [LW-1:0]         rd_addr;
    t_slot                 slot_wdata, slot_rd;
    logic [RING_DEPTH-1:0] slot_valid;

    logic  emit, emit_ok, push, oreg_can;
    t_out  emit_item, push_item;

    function automatic logic [LW-1:0] inc_slot(input logic [LW-1:0] s);
        return (s == LW'(RING_DEPTH - 1)) ? '0 : s + LW'(1);
    endfunction

    crpb_alu u_alu (
        .i_a      (alu_a),
        .i_b      (alu_b),
        .i_sub    (alu_sub),
        .o_res    (alu_res),
        .o_borrow (alu_borrow)
    );

    crpb_mod #(.RING_DEPTH(RING_DEPTH)) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_value (i_item.chunk_id),
        .o_busy  (mod_busy),
        .o_rem   (mod_rem)
    );

    // The arriving chunk's slot is read while deciding and storing,
    // else the expected slot.
    assign rd_addr = (r_st == S_ARRIVE || r_st == S_STORE) ? mod_rem : r_eslot;

    assign slot_wdata = '{id:     r_in.chunk_id,
                          handle: r_in.payload_handle,
                          size:   r_in.payload_size,
                          stamp:  r_in.stamp};

    crpb_slots #(.RING_DEPTH(RING_DEPTH)) u_slots (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (slot_wr),
        .i_wr_addr  (mod_rem),
        .i_wr_data  (slot_wdata),
        .i_clr      (slot_clr),
        .i_clr_addr (r_eslot),
        .i_rd_addr  (rd_addr),
        .o_rd_data  (slot_rd),
        .o_valid    (slot_valid)
    );

    crpb_oreg u_oreg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_can   (oreg_can),
        .o_valid (o_valid),
        .o_item  (o_item),
        .i_ready (i_ready)
    );

    assign o_ready = (r_st == S_IDLE);
    assign emit_ok = !r_pend_v || oreg_can;

    // Operand select for the shared unit; default is expected id + 1.
    always_comb begin
        alu_a   = {1'b0, r_exp};
        alu_b   = ALU_W'(1);
        alu_sub = 1'b0;
        unique case (r_st)
            S_MOD, S_ARRIVE: begin
                alu_a   = {1'b0, r_in.chunk_id};
                alu_b   = {1'b0, r_exp};
                alu_sub = 1'b1;
            end
            S_JUMP: begin
                alu_a   = r_tmp;
                alu_b   = BM1;
                alu_sub = 1'b1;
            end
            S_EXTRA: begin
                alu_a   = r_tmp;
                alu_b   = B32;
                alu_sub = 1'b1;
            end
            S_LAST: begin
                alu_a   = {1'b0, r_in.chunk_id};
                alu_b   = BM1;
                alu_sub = 1'b1;
            end
            default: begin
                alu_a   = {1'b0, r_exp};
                alu_b   = ALU_W'(1);
                alu_sub = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_st      = r_st;
        n_in      = r_in;
        n_started = r_started;
        n_exp     = r_exp;
        n_eslot   = r_eslot;
        n_tmp     = r_tmp;
        n_cnt     = r_cnt;
        n_extra   = r_extra;
        n_after   = r_after;
        n_pend    = r_pend;
        n_pend_v  = r_pend_v;
        emit      = 1'b0;
        emit_item = '0;
        push      = 1'b0;
        push_item = r_pend;
        slot_wr   = 1'b0;
        slot_clr  = 1'b0;
        mod_start = 1'b0;

        unique case (r_st)
            S_IDLE: begin
                if (i_valid) begin
                    n_in      = i_item;
                    n_after   = 1'b0;
                    mod_start = 1'b1;
                    n_st      = S_MOD;
                end
            end
            S_MOD: begin
                if (!mod_busy) begin
                    if (r_started && alu_borrow) begin
                        n_st = S_IDLE;              // late chunk, dropped
                    end else if (!r_started) begin
                        n_started = 1'b1;
                        n_exp     = r_in.chunk_id;
                        n_eslot   = mod_rem;
                        n_st      = S_ARRIVE;
                    end else begin
                        n_tmp = alu_res;
                        n_st  = (alu_res >= B32) ? S_JUMP : S_ARRIVE;
                    end
                end
            end
            S_JUMP: begin
                n_tmp   = alu_res;
                n_cnt   = (alu_res >= B32) ? CW'(RING_DEPTH) : alu_res[CW-1:0];
                n_extra = (alu_res > B32);
                n_st    = S_WRD;
            end
            S_WRD: begin
                n_st = S_WUSE;
            end
            S_WUSE: begin
                if (emit_ok) begin
                    emit = 1'b1;
                    if (slot_valid[r_eslot]) begin
                        emit_item.event_kind = EV_PLAY;
                        emit_item.out_id     = slot_rd.id;
                        emit_item.out_handle = slot_rd.handle;
                        emit_item.out_size   = slot_rd.size;
                        emit_item.out_stamp  = slot_rd.stamp;
                        slot_clr             = 1'b1;
                    end else begin
                        emit_item.event_kind = EV_LOST;
                        emit_item.out_id     = r_in.chunk_id;
                        emit_item.out_stamp  = r_in.stamp;
                        emit_item.lost_count = ID_W'(1);
                    end
                    n_exp   = alu_res[ID_W-1:0];
                    n_eslot = alu_res[ID_W] ? '0 : inc_slot(r_eslot);
                    if (r_cnt == CW'(1)) begin
                        if (r_extra) begin
                            n_st = S_EXTRA;
                        end else begin
                            n_cnt = CW'(RING_DEPTH);
                            n_st  = S_RRD;
                        end
                    end else begin
                        n_cnt = r_cnt - CW'(1);
                        n_st  = S_WRD;
                    end
                end
            end
            S_EXTRA: begin
                if (emit_ok) begin
                    emit                 = 1'b1;
                    emit_item.event_kind = EV_LOST;
                    emit_item.out_id     = r_in.chunk_id;
                    emit_item.out_stamp  = r_in.stamp;
                    emit_item.lost_count = alu_res[ID_W-1:0];
                    n_st                 = S_LAST;
                end
            end
            S_LAST: begin
                // expected = id - RING_DEPTH + 1, same slot as id + 1
                n_exp   = alu_res[ID_W-1:0];
                n_eslot = inc_slot(mod_rem);
                n_cnt   = CW'(RING_DEPTH);
                n_st    = S_RRD;
            end
            S_RRD: begin
                if (r_cnt != '0 && slot_valid[r_eslot]) begin
                    n_st = S_RUSE;
                end else begin
                    n_st = r_after ? S_FIN : S_ARRIVE;
                end
            end
            S_RUSE: begin
                if (emit_ok) begin
                    emit                 = 1'b1;
                    emit_item.event_kind = EV_PLAY;
                    emit_item.out_id     = slot_rd.id;
                    emit_item.out_handle = slot_rd.handle;
                    emit_item.out_size   = slot_rd.size;
                    emit_item.out_stamp  = slot_rd.stamp;
                    slot_clr             = 1'b1;
                    n_exp                = alu_res[ID_W-1:0];
                    n_eslot              = alu_res[ID_W] ? '0 : inc_slot(r_eslot);
                    n_cnt                = r_cnt - CW'(1);
                    n_st                 = S_RRD;
                end
            end
            S_ARRIVE: begin
                n_st = (alu_res == '0) ? S_APLAY : S_STORE;
            end
            S_APLAY: begin
                if (emit_ok) begin
                    emit                 = 1'b1;
                    emit_item.event_kind = EV_PLAY;
                    emit_item.out_id     = r_in.chunk_id;
                    emit_item.out_handle = r_in.payload_handle;
                    emit_item.out_size   = r_in.payload_size;
                    emit_item.out_stamp  = r_in.stamp;
                    n_exp                = alu_res[ID_W-1:0];
                    n_eslot              = alu_res[ID_W] ? '0 : inc_slot(r_eslot);
                    n_after              = 1'b1;
                    n_cnt                = CW'(RING_DEPTH);
                    n_st                 = S_RRD;
                end
            end
            S_STORE: begin
                if (slot_valid[mod_rem]) begin
                    if (emit_ok) begin
                        emit                 = 1'b1;
                        emit_item.event_kind = (slot_rd.id == r_in.chunk_id) ? EV_DUP
                                                                             : EV_ERR;
                        emit_item.out_id     = r_in.chunk_id;
                        n_st                 = S_FIN;
                    end
                end else begin
                    slot_wr = 1'b1;
                    n_st    = S_FIN;
                end
            end
            S_FIN: begin
                if (r_pend_v) begin
                    if (oreg_can) begin
                        push                  = 1'b1;
                        push_item.last_result = 1'b1;
                        n_pend_v              = 1'b0;
                        n_st                  = S_IDLE;
                    end
                end else begin
                    n_st = S_IDLE;
                end
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase

        // A new result releases the held one, which is then known not last.
        if (emit) begin
            push     = r_pend_v;
            n_pend   = emit_item;
            n_pend_v = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= S_IDLE;
            r_started <= 1'b0;
            r_exp     <= '0;
            r_eslot   <= '0;
            r_cnt     <= '0;
            r_extra   <= 1'b0;
            r_after   <= 1'b0;
            r_pend_v  <= 1'b0;
        end else begin
            r_st      <= n_st;
            r_started <= n_started;
            r_exp     <= n_exp;
            r_eslot   <= n_eslot;
            r_cnt     <= n_cnt;
            r_extra   <= n_extra;
            r_after   <= n_after;
            r_pend_v  <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in   <= n_in;
        r_tmp  <= n_tmp;
        r_pend <= n_pend;
    end

    // Nothing may be held over between input items.
    a_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_IDLE |-> !r_pend_v)
        else $error("result held while idle");

    // The output register must have room whenever a result is pushed.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> oreg_can)
        else $error("push into full output register");

    a_eslot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_eslot <= LW'(RING_DEPTH - 1))
        else $error("expected slot out of range");

    // A release step only ever plays a slot that the read step saw valid.
    a_play_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_RUSE |-> slot_valid[r_eslot])
        else $error("release of an empty slot");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the chunk reorder playout buffer.
module tb;
    import crpb_pkg::*;

    localparam int          BUFF      = 8;
    localparam logic [30:0] MAX_ID    = 31'h7FFF_FFFF;
    localparam int          IDLE_LIM  = 3000;   // cycles with no item moving on either side
    localparam int          TAIL_CYC  = 60;     // quiet time after the last result
    localparam int          PHASE_LEN = 22;     // chunks per random phase, late ones not counted
    localparam int          MAX_SHOWN = 10;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    t_in  i_item  = '0;
    logic o_ready;
    logic o_valid;
    t_out o_item;

    // Idling knobs, percent of cycles.
    int send_idle  = 0;
    int recv_stall = 0;

    // Playout model state.
    logic        pb_started = 1'b0;
    logic [30:0] pb_next_id = '0;
    logic        pb_held [BUFF];
    t_slot       pb_slot [BUFF];
    t_out        step_results [$];
    t_out        playout_q [$];

    int errors      = 0;
    int chunks_sent = 0;
    int late_drops  = 0;
    int kind_seen [4];
    int idle_cycles = 0;

    chunk_reorder_playout_buffer_top #(
        .RING_DEPTH(BUFF)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_item (i_item),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_item (o_item)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        foreach (pb_held[k]) pb_held[k] = 1'b0;
        foreach (kind_seen[k]) kind_seen[k] = 0;
    end

    // Result side backpressure, changed on the falling edge.
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_stall);
    end

    // ------------------------------------------------------------------
    // Playout model: one call per accepted chunk, appends the results it
    // causes to playout_q.
    // ------------------------------------------------------------------
    task automatic emit_result(input t_event kind, input logic [30:0] id,
                               input logic [15:0] hdl, input logic [15:0] sz,
                               input logic [63:0] st, input logic [30:0] cnt);
        t_out r;
        r.event_kind  = kind;
        r.out_id      = id;
        r.out_handle  = hdl;
        r.out_size    = sz;
        r.out_stamp   = st;
        r.lost_count  = cnt;
        r.last_result = 1'b0;
        step_results.push_back(r);
    endtask

    task automatic play_held(input int k);
        emit_result(EV_PLAY, pb_slot[k].id, pb_slot[k].handle, pb_slot[k].size,
                    pb_slot[k].stamp, '0);
        pb_held[k] = 1'b0;
        pb_next_id = pb_slot[k].id + 31'd1;
    endtask

    // Play stored successors of the expected id, at most one ring's worth.
    task automatic release_held_run();
        int first;
        int k;
        first = pb_next_id % BUFF;
        k     = first;
        while (pb_held[k]) begin
            play_held(k);
            k = (k + 1) % BUFF;
            if (k == first) break;
        end
    endtask

    task automatic predict_playout(input t_in c);
        logic [63:0] n;
        logic [63:0] e;
        logic [63:0] last;
        logic [63:0] win_end;
        logic [63:0] pos;
        int          k;
        n = 64'(c.chunk_id);
        step_results.delete();
        if (pb_started && n < 64'(pb_next_id)) begin
            late_drops++;
            return;
        end
        if (!pb_started) begin
            pb_started = 1'b1;
            pb_next_id = c.chunk_id;
        end

        // Window jump: positions within one ring play or report loss one by
        // one, anything further is folded into a single lost report.
        if (n >= 64'(pb_next_id) + BUFF) begin
            e       = 64'(pb_next_id);
            last    = n - BUFF;
            win_end = e + BUFF - 1;
            if (win_end > last) win_end = last;
            for (pos = e; pos <= win_end; pos++) begin
                k = int'(pos % BUFF);
                if (pb_held[k]) begin
                    play_held(k);
                end else begin
                    emit_result(EV_LOST, c.chunk_id, '0, '0, c.stamp, 31'd1);
                    pb_next_id = 31'(pos + 1);
                end
            end
            if (last > win_end) begin
                emit_result(EV_LOST, c.chunk_id, '0, '0, c.stamp, 31'(last - win_end));
                pb_next_id = 31'(last + 1);
            end
            release_held_run();
        end

        if (c.chunk_id == pb_next_id) begin
            emit_result(EV_PLAY, c.chunk_id, c.payload_handle, c.payload_size, c.stamp, '0);
            pb_next_id = c.chunk_id + 31'd1;
            release_held_run();
        end else begin
            k = int'(c.chunk_id % BUFF);
            if (pb_held[k]) begin
                if (pb_slot[k].id == c.chunk_id)
                    emit_result(EV_DUP, c.chunk_id, '0, '0, '0, '0);
                else
                    emit_result(EV_ERR, c.chunk_id, '0, '0, '0, '0);
            end else begin
                pb_held[k]        = 1'b1;
                pb_slot[k].id     = c.chunk_id;
                pb_slot[k].handle = c.payload_handle;
                pb_slot[k].size   = c.payload_size;
                pb_slot[k].stamp  = c.stamp;
            end
        end

        if (step_results.size() > 0) step_results[$].last_result = 1'b1;
        foreach (step_results[j]) playout_q.push_back(step_results[j]);
    endtask

    // ------------------------------------------------------------------
    // Sender. Entered and left on a falling edge; valid is only dropped
    // when a gap is taken, so it never toggles twice in one step.
    // ------------------------------------------------------------------
    task automatic send_chunk(input logic [30:0] id, input logic [15:0] hdl,
                              input logic [15:0] sz, input logic [63:0] st);
        t_in c;
        c.chunk_id       = id;
        c.payload_handle = hdl;
        c.payload_size   = sz;
        c.stamp          = st;
        while ($urandom_range(0, 99) < send_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= c;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
        chunks_sent++;
        predict_playout(c);
    endtask

    // Hold the sender until every expected result has been taken.
    task automatic drain_pause();
        i_valid <= 1'b0;
        while (playout_q.size() != 0) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Result checker and stall watchdog, both on the rising edge.
    // ------------------------------------------------------------------
    function automatic bit result_matches(input t_out a, input t_out b);
        return a.event_kind  === b.event_kind  &&
               a.out_id      === b.out_id      &&
               a.out_handle  === b.out_handle  &&
               a.out_size    === b.out_size    &&
               a.out_stamp   === b.out_stamp   &&
               a.lost_count  === b.lost_count  &&
               a.last_result === b.last_result;
    endfunction

    always @(posedge i_clk) begin : check_results
        t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (o_item.event_kind !== 2'bxx) kind_seen[o_item.event_kind]++;
            if (playout_q.size() == 0) begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("unexpected result: kind=%0d id=%0d cnt=%0d last=%b",
                             o_item.event_kind, o_item.out_id, o_item.lost_count,
                             o_item.last_result);
            end else begin
                want = playout_q.pop_front();
                if (!result_matches(want, o_item)) begin
                    errors++;
                    if (errors <= MAX_SHOWN) begin
                        $display("mismatch exp: kind=%0d id=%0d h=%h sz=%h st=%h cnt=%0d last=%b",
                                 want.event_kind, want.out_id, want.out_handle,
                                 want.out_size, want.out_stamp, want.lost_count,
                                 want.last_result);
                        $display("         got: kind=%0d id=%0d h=%h sz=%h st=%h cnt=%0d last=%b",
                                 o_item.event_kind, o_item.out_id, o_item.out_handle,
                                 o_item.out_size, o_item.out_stamp, o_item.lost_count,
                                 o_item.last_result);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIM) begin
                $display("timeout: nothing moved for %0d cycles", IDLE_LIM);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed tests, in the order the state builds up.
    // ------------------------------------------------------------------

    // First chunk sets the expected id and plays at once; field extremes.
    task automatic test_first_chunk();
        send_chunk(31'd1000, 16'hFFFF, 16'h0000, '1);
    endtask

    // Two stored successors get pulled out by the missing one.
    task automatic test_out_of_order();
        send_chunk(31'd1003, 16'h0000, 16'hFFFF, '0);
        send_chunk(31'd1002, 16'($urandom), 16'($urandom), {$urandom, $urandom});
        send_chunk(31'd1001, 16'($urandom), 16'($urandom), {$urandom, $urandom});
    endtask

    // Ids behind the expected one vanish without a result.
    task automatic test_late_drop();
        send_chunk(31'd999, 16'($urandom), 16'($urandom), {$urandom, $urandom});
        send_chunk(31'd0, 16'hFFFF, 16'hFFFF, '1);
    endtask

    task automatic test_duplicate();
        send_chunk(31'd1006, 16'h1234, 16'h0042, {$urandom, $urandom});
        send_chunk(31'd1006, 16'($urandom), 16'($urandom), {$urandom, $urandom});
    endtask

    // Jump a little past the window: losses mixed with stored plays.
    task automatic test_window_jump();
        send_chunk(31'd1007, 16'($urandom), 16'($urandom), {$urandom, $urandom});
        send_chunk(31'd1015, 16'($urandom), 16'($urandom), {$urandom, $urandom});
    endtask

    // Jump far ahead: one ring played or reported lost one by one, then one counted report.
    task automatic test_coalesced_loss();
        send_chunk(31'd1009, 16'($urandom), 16'($urandom), {$urandom, $urandom});
        send_chunk(31'd1048, 16'($urandom), 16'($urandom), {$urandom, $urandom});
    endtask

    // Top id is stored, the ring fills behind it and one chunk releases the
    // lot; expected id wraps to zero and id zero plays.
    task automatic test_counter_wrap();
        send_chunk(MAX_ID, 16'($urandom), 16'($urandom), {$urandom, $urandom});
        for (int d = 1; d <= 6; d++)
            send_chunk(MAX_ID - 31'(d), 16'($urandom), 16'($urandom), {$urandom, $urandom});
        send_chunk(MAX_ID - 31'd7, 16'($urandom), 16'($urandom), {$urandom, $urandom});
        send_chunk(31'd0, 16'h0000, 16'h0000, '0);
    endtask

    // ------------------------------------------------------------------
    // Random traffic: mostly ids around the expected one, with jumps,
    // repeats of stored ids and late ids mixed in.
    // ------------------------------------------------------------------
    task automatic make_random_chunk(output t_in c);
        int          pick;
        logic [30:0] held_ids [$];
        pick             = $urandom_range(0, 99);
        c.payload_handle = 16'($urandom);
        c.payload_size   = 16'($urandom);
        c.stamp          = {$urandom, $urandom};
        foreach (pb_held[k])
            if (pb_held[k]) held_ids.push_back(pb_slot[k].id);
        if (pick < 55)
            c.chunk_id = pb_next_id + 31'($urandom_range(0, 7));
        else if (pick < 67)
            c.chunk_id = pb_next_id + 31'($urandom_range(8, 15));
        else if (pick < 77 && held_ids.size() > 0)
            c.chunk_id = held_ids[$urandom_range(0, held_ids.size() - 1)];
        else if (pick < 85 && pb_next_id > 31'd8)
            c.chunk_id = pb_next_id - 31'($urandom_range(1, 8));
        else if (pick < 96)
            c.chunk_id = pb_next_id + 31'($urandom_range(16, 300));
        else
            c.chunk_id = 31'($urandom);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        t_in c;
        bit  late;
        int  counted;
        send_idle  = idle_pct;
        recv_stall = stall_pct;
        counted    = 0;
        while (counted < PHASE_LEN) begin
            make_random_chunk(c);
            late = pb_started && c.chunk_id < pb_next_id;
            send_chunk(c.chunk_id, c.payload_handle, c.payload_size, c.stamp);
            if (!late) counted++;
        end
        drain_pause();
    endtask

    // ------------------------------------------------------------------
    // Run order.
    // ------------------------------------------------------------------
    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_first_chunk();
        test_out_of_order();
        test_late_drop();
        test_duplicate();
        test_window_jump();
        test_coalesced_loss();
        test_counter_wrap();
        drain_pause();

        test_random_traffic(0, 0);
        test_random_traffic(70, 0);
        test_random_traffic(0, 70);
        test_random_traffic(9, 9);

        // Wind down: nothing left to send, wait for the tail.
        i_valid <= 1'b0;
        while (playout_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYC) @(posedge i_clk);
        errors += playout_q.size();

        $display("run: %0d chunks sent, %0d dropped as late", chunks_sent, late_drops);
        $display("results: %0d played, %0d lost, %0d duplicate, %0d collision",
                 kind_seen[EV_PLAY], kind_seen[EV_LOST], kind_seen[EV_DUP], kind_seen[EV_ERR]);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ files.f @@
src/crpb_pkg.sv
src/crpb_alu.sv
src/crpb_mod.sv
src/crpb_slots.sv
src/crpb_oreg.sv
src/chunk_reorder_playout_buffer_top.sv
tb/tb.sv
